/* src/sla_pkg.sv */
package sla_pkg;

   // Q16.16 constants
   localparam int FRAC_BITS = 16;
   localparam int DEF_CELLS = 63;
   localparam int IDX_W     = 6;
   localparam int DATA_W    = 32;
   localparam int RATIO_W   = 31;
   localparam logic [RATIO_W-1:0] RATIO_RESET = 31'd65536;

   // request codes
   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_ADVECT = 1'b1
   } req_code_type;

endpackage

/* src/sla_queue.sv */
// Short FIFO between the front (accept) and back (execute) parts.
module sla_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data,
   output logic [$clog2(DEPTH+1)-1:0] fill
);
   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [$clog2(DEPTH+1)-1:0] cnt_ff, cnt_in;

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign not_empty = (cnt_ff != '0);
   assign pop_data  = slot_ff[rd_ff];
   assign fill      = cnt_ff;

   no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("queue popped while empty");
   no_push_full: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> cnt_ff != ($clog2(DEPTH+1))'(DEPTH))
      else $error("queue pushed while full");
endmodule

/* src/sla_front.sv */
// Front: takes words, traces back, clamps and classifies into queue entries.
// Stage 1: ratio*velocity products. Stage 2: clamp, split, boundary flag.
module sla_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         in_type,
   input  logic [sla_pkg::IDX_W-1:0]    in_row,
   input  logic [sla_pkg::IDX_W-1:0]    in_col,
   input  logic signed [sla_pkg::DATA_W-1:0] in_src,
   input  logic signed [sla_pkg::DATA_W-1:0] in_vr,
   input  logic signed [sla_pkg::DATA_W-1:0] in_vc,
   input  logic [sla_pkg::RATIO_W-1:0] ratio,
   output logic                         out_valid,
   output logic                         out_type,
   output logic                         out_bound,
   output logic [sla_pkg::IDX_W-1:0]    out_row,
   output logic [sla_pkg::IDX_W-1:0]    out_col,
   output logic [sla_pkg::DATA_W-1:0]   out_src,
   output logic [sla_pkg::IDX_W-1:0]    out_ir,
   output logic [sla_pkg::IDX_W-1:0]    out_ic,
   output logic [sla_pkg::FRAC_BITS-1:0] out_fr,
   output logic [sla_pkg::FRAC_BITS-1:0] out_fc
);
   import sla_pkg::*;

   localparam int CELLS  = DEF_CELLS;
   localparam int PROD_W = DATA_W + RATIO_W + 1;
   localparam int OFF_W  = PROD_W - FRAC_BITS;
   localparam int PT_W   = OFF_W + 2;
   localparam logic signed [PT_W-1:0] LO_PT = PT_W'(1 << (FRAC_BITS-1));
   localparam logic signed [PT_W-1:0] HI_PT =
      PT_W'((CELLS << FRAC_BITS) - (1 << (FRAC_BITS-1)));

   // stage 1 registers
   logic                      v1_ff;
   logic                      t1_ff;
   logic [IDX_W-1:0]          r1_ff, c1_ff;
   logic [DATA_W-1:0]         s1_ff;
   logic signed [PROD_W-1:0]  pr1_ff, pc1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      t1_ff  <= in_type;
      r1_ff  <= in_row;
      c1_ff  <= in_col;
      s1_ff  <= in_src;
      pr1_ff <= $signed({1'b0, ratio}) * in_vr;
      pc1_ff <= $signed({1'b0, ratio}) * in_vc;
   end

   // clamp of index*2^16 - floor(prod/2^16)
   function automatic logic [PT_W-1:0] clamp_pt(input logic [IDX_W-1:0] idx,
                                                input logic signed [PROD_W-1:0] p);
      logic signed [PT_W-1:0] pt;
      begin
         pt = $signed(PT_W'({idx, {FRAC_BITS{1'b0}}}))
              - PT_W'(p >>> FRAC_BITS);
         if (pt < LO_PT) begin
            pt = LO_PT;
         end
         if (pt > HI_PT) begin
            pt = HI_PT;
         end
         return pt;
      end
   endfunction

   logic [PT_W-1:0] ptr, ptc;
   assign ptr = clamp_pt(r1_ff, pr1_ff);
   assign ptc = clamp_pt(c1_ff, pc1_ff);

   // stage 2 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= v1_ff;
      end
      out_type  <= t1_ff;
      out_row   <= r1_ff;
      out_col   <= c1_ff;
      out_src   <= s1_ff;
      out_bound <= (r1_ff == '0) || (c1_ff == '0) ||
                   ({1'b0, r1_ff} >= (IDX_W+1)'(CELLS)) ||
                   ({1'b0, c1_ff} >= (IDX_W+1)'(CELLS));
      out_ir    <= ptr[FRAC_BITS +: IDX_W];
      out_ic    <= ptc[FRAC_BITS +: IDX_W];
      out_fr    <= ptr[FRAC_BITS-1:0];
      out_fc    <= ptc[FRAC_BITS-1:0];
   end
endmodule

/* src/sla_back.sv */
// Back: pops queue entries, writes loads, reads four neighbors and blends.
// Store is split into four banks by row and column parity so one read
// fetches the 2x2 neighborhood.
module sla_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         in_type,
   input  logic                         in_bound,
   input  logic [sla_pkg::IDX_W-1:0]    in_row,
   input  logic [sla_pkg::IDX_W-1:0]    in_col,
   input  logic [sla_pkg::DATA_W-1:0]   in_src,
   input  logic [sla_pkg::IDX_W-1:0]    in_ir,
   input  logic [sla_pkg::IDX_W-1:0]    in_ic,
   input  logic [sla_pkg::FRAC_BITS-1:0] in_fr,
   input  logic [sla_pkg::FRAC_BITS-1:0] in_fc,
   output logic                         out_valid,
   output logic [sla_pkg::IDX_W-1:0]    out_row,
   output logic [sla_pkg::IDX_W-1:0]    out_col,
   output logic [sla_pkg::DATA_W-1:0]   out_value
);
   import sla_pkg::*;

   localparam int CELLS = DEF_CELLS;
   localparam int H_W   = IDX_W - 1;
   localparam int BANK  = 1 << (2*H_W);
   localparam int BL_W  = DATA_W + FRAC_BITS + 2;
   localparam int ONE   = 1 << FRAC_BITS;
   localparam int HALF  = 1 << (FRAC_BITS-1);

   logic signed [DATA_W-1:0] bank00 [BANK];
   logic signed [DATA_W-1:0] bank01 [BANK];
   logic signed [DATA_W-1:0] bank10 [BANK];
   logic signed [DATA_W-1:0] bank11 [BANK];

   // load write: bank chosen by parity of row and column
   logic [2*H_W-1:0] wa;
   logic             wen;
   assign wa  = {in_row[IDX_W-1:1], in_col[IDX_W-1:1]};
   assign wen = in_valid && (in_type == REQ_LOAD) &&
                ({1'b0, in_row} <= (IDX_W+1)'(CELLS)) &&
                ({1'b0, in_col} <= (IDX_W+1)'(CELLS));

   // read addresses: neighbor rows ir and ir+1, cols ic and ic+1
   logic [IDX_W-1:0] r_a, r_b, c_a, c_b;
   assign r_a = in_ir;
   assign r_b = in_ir + 1'b1;
   assign c_a = in_ic;
   assign c_b = in_ic + 1'b1;
   // even/odd row (col) index among the pair
   logic [H_W-1:0] re, ro, ce, co;
   assign re = in_ir[0] ? r_b[IDX_W-1:1] : r_a[IDX_W-1:1];
   assign ro = in_ir[0] ? r_a[IDX_W-1:1] : r_b[IDX_W-1:1];
   assign ce = in_ic[0] ? c_b[IDX_W-1:1] : c_a[IDX_W-1:1];
   assign co = in_ic[0] ? c_a[IDX_W-1:1] : c_b[IDX_W-1:1];

   logic signed [DATA_W-1:0] q00_ff, q01_ff, q10_ff, q11_ff;
   always_ff @(posedge clock) begin
      if (wen) begin
         case ({in_row[0], in_col[0]})
            2'b00:   bank00[wa] <= in_src;
            2'b01:   bank01[wa] <= in_src;
            2'b10:   bank10[wa] <= in_src;
            default: bank11[wa] <= in_src;
         endcase
      end
      q00_ff <= bank00[{re, ce}];
      q01_ff <= bank01[{re, co}];
      q10_ff <= bank10[{ro, ce}];
      q11_ff <= bank11[{ro, co}];
   end

   // stage A: read
   logic                 va_ff, ba_ff, swr_ff, swc_ff;
   logic [IDX_W-1:0]     ra_ff, ca_ff;
   logic [FRAC_BITS-1:0] fra_ff, fca_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_valid && (in_type == REQ_ADVECT);
      end
      ba_ff  <= in_bound;
      swr_ff <= in_ir[0];
      swc_ff <= in_ic[0];
      ra_ff  <= in_row;
      ca_ff  <= in_col;
      fra_ff <= in_fr;
      fca_ff <= in_fc;
   end

   // neighbors in order: s(ir,ic) s(ir,ic+1) s(ir+1,ic) s(ir+1,ic+1)
   logic signed [DATA_W-1:0] s00, s01, s10, s11;
   always_comb begin
      case ({swr_ff, swc_ff})
         2'b00: begin
            s00 = q00_ff; s01 = q01_ff; s10 = q10_ff; s11 = q11_ff;
         end
         2'b01: begin
            s00 = q01_ff; s01 = q00_ff; s10 = q11_ff; s11 = q10_ff;
         end
         2'b10: begin
            s00 = q10_ff; s01 = q11_ff; s10 = q00_ff; s11 = q01_ff;
         end
         default: begin
            s00 = q11_ff; s01 = q10_ff; s10 = q01_ff; s11 = q00_ff;
         end
      endcase
   end

   // a + f*(b-a): same value as (1-f)a + fb, one multiply per blend
   function automatic logic signed [BL_W-1:0] lerp(
      input logic signed [DATA_W:0] a, input logic signed [DATA_W:0] b,
      input logic [FRAC_BITS-1:0] f);
      logic signed [BL_W-1:0] d;
      logic signed [BL_W+FRAC_BITS-1:0] t;
      begin
         d = BL_W'(b) - BL_W'(a);
         t = (BL_W+FRAC_BITS)'(a) * (BL_W+FRAC_BITS)'(ONE)
             + d * $signed({1'b0, f}) + (BL_W+FRAC_BITS)'(HALF);
         return BL_W'(t >>> FRAC_BITS);
      end
   endfunction

   // stage B: column blends
   logic                     vb_ff, bb_ff;
   logic [IDX_W-1:0]         rb_ff, cb_ff;
   logic [FRAC_BITS-1:0]     frb_ff;
   logic signed [DATA_W:0]   ab_ff, bb2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
      bb_ff  <= ba_ff;
      rb_ff  <= ra_ff;
      cb_ff  <= ca_ff;
      frb_ff <= fra_ff;
      ab_ff  <= (DATA_W+1)'(lerp(DATA_W'(s00), DATA_W'(s01), fca_ff));
      bb2_ff <= (DATA_W+1)'(lerp(DATA_W'(s10), DATA_W'(s11), fca_ff));
   end

   // stage C: row blend, saturate, register result
   logic signed [BL_W-1:0] v;
   logic signed [DATA_W-1:0] sat;
   assign v = lerp(ab_ff, bb2_ff, frb_ff);
   always_comb begin
      if (v > BL_W'(32'sh7FFF_FFFF)) begin
         sat = 32'sh7FFF_FFFF;
      end else if (v < -BL_W'(33'sh0_8000_0000)) begin
         sat = 32'sh8000_0000;
      end else begin
         sat = DATA_W'(v);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= vb_ff;
      end
      out_row   <= rb_ff;
      out_col   <= cb_ff;
      out_value <= bb_ff ? '0 : sat;
   end

   bound_zero: assert property (@(posedge clock) disable iff (reset)
      (vb_ff && bb_ff) |=> (out_valid && out_value == '0))
      else $error("boundary cell gave nonzero value");
endmodule

/* src/semi_lagrangian_advection_top.sv */
// Channel  | handshake        | words
// request  | start / busy     | req_type, req_row, req_col, req_source_value,
//          |                  | req_vel_row, req_vel_col
// response | rsp_valid strobe | rsp_out_row, rsp_out_col, rsp_advected_value
// config   | csr_write        | csr_wdata -> trace_ratio
// One word accepted per cycle; a result is on the rsp_ ports for one cycle, after
// its request passes two front stages, the queue register and three back stages.
// Reset clears control state and sets trace_ratio to 1.0; the store is undefined.
// The receiver cannot stall, so the queue never fills and busy stays low.
module semi_lagrangian_advection_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [sla_pkg::IDX_W-1:0]     req_row,
   input  logic [sla_pkg::IDX_W-1:0]     req_col,
   input  logic signed [sla_pkg::DATA_W-1:0] req_source_value,
   input  logic signed [sla_pkg::DATA_W-1:0] req_vel_row,
   input  logic signed [sla_pkg::DATA_W-1:0] req_vel_col,
   output logic                          rsp_valid,
   output logic [sla_pkg::IDX_W-1:0]     rsp_out_row,
   output logic [sla_pkg::IDX_W-1:0]     rsp_out_col,
   output logic signed [sla_pkg::DATA_W-1:0] rsp_advected_value,
   input  logic                          csr_write,
   input  logic [sla_pkg::RATIO_W-1:0]   csr_wdata
);
   import sla_pkg::*;

   localparam int QD = 2;
   localparam int QW = 1 + 1 + 4*IDX_W + DATA_W + 2*FRAC_BITS;

   logic [RATIO_W-1:0] ratio_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_RESET;
      end else if (csr_write) begin
         ratio_ff <= csr_wdata;
      end
   end

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   logic f_valid, f_type, f_bound;
   logic [IDX_W-1:0] f_row, f_col, f_ir, f_ic;
   logic [DATA_W-1:0] f_src;
   logic [FRAC_BITS-1:0] f_fr, f_fc;

   sla_front u_front (
      .clock, .reset, .in_valid(accept), .in_type(req_type),
      .in_row(req_row), .in_col(req_col), .in_src(req_source_value),
      .in_vr(req_vel_row), .in_vc(req_vel_col), .ratio(ratio_ff),
      .out_valid(f_valid), .out_type(f_type), .out_bound(f_bound),
      .out_row(f_row), .out_col(f_col), .out_src(f_src),
      .out_ir(f_ir), .out_ic(f_ic), .out_fr(f_fr), .out_fc(f_fc));

   // queue between front and back; back drains one word each cycle
   logic q_ne;
   logic [QW-1:0] q_out;
   logic [$clog2(QD+1)-1:0] q_fill;
   logic b_type, b_bound;
   logic [IDX_W-1:0] b_row, b_col, b_ir, b_ic;
   logic [DATA_W-1:0] b_src;
   logic [FRAC_BITS-1:0] b_fr, b_fc;

   sla_queue #(.WIDTH(QW), .DEPTH(QD)) u_queue (
      .clock, .reset, .push(f_valid),
      .push_data({f_type, f_bound, f_row, f_col, f_ir, f_ic, f_src, f_fr, f_fc}),
      .pop(q_ne), .not_empty(q_ne), .pop_data(q_out), .fill(q_fill));
   assign {b_type, b_bound, b_row, b_col, b_ir, b_ic, b_src, b_fr, b_fc} = q_out;

   sla_back u_back (
      .clock, .reset, .in_valid(q_ne), .in_type(b_type), .in_bound(b_bound),
      .in_row(b_row), .in_col(b_col), .in_src(b_src), .in_ir(b_ir),
      .in_ic(b_ic), .in_fr(b_fr), .in_fc(b_fc),
      .out_valid(rsp_valid), .out_row(rsp_out_row), .out_col(rsp_out_col),
      .out_value(rsp_advected_value));

   queue_shallow: assert property (@(posedge clock) disable iff (reset)
      q_fill <= ($clog2(QD+1))'(1)) else $error("queue backed up");
   ratio_held: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_write) |-> $stable(ratio_ff)) else $error("ratio changed");
   load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_LOAD) |-> ##6 !rsp_valid)
      else $error("load word produced a result");
   advect_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_ADVECT) |-> ##6 rsp_valid)
      else $error("advect word produced no result");
endmodule
